// ===== sv/mme_pkg.sv =====
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants
// Register indexes, fixed field widths and lane control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

	localparam int BSW  = 9;   // batch_size register width
	localparam int UCW  = 24;  // update counter width
	localparam int IDXW = 3;   // config index width

	localparam logic [IDXW-1:0] REG_BATCH_SIZE = 3'd0;
	localparam logic [IDXW-1:0] REG_INITIAL_X  = 3'd1;
	localparam logic [IDXW-1:0] REG_INITIAL_Y  = 3'd2;
	localparam logic [IDXW-1:0] REG_TARGET_X   = 3'd3;
	localparam logic [IDXW-1:0] REG_TARGET_Y   = 3'd4;

	typedef struct packed {
		logic acc;      // add sample to batch sum
		logic restart;  // reload estimate, drop partial batch
		logic prep;     // form numerator/denominator, then divide
	} lane_ctl_t;

endpackage

`default_nettype wire

// ===== sv/mme_lane.sv =====
// ----------------------------------------------------------------------------
// mme_lane: one coordinate lane
// Batch sum, estimate register and a restoring divider for the step update.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_lane import mme_pkg::*; #(
	parameter int CW = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lane_ctl_t             ctl,
	input  wire logic signed [CW-1:0]  sample,
	input  wire logic signed [CW-1:0]  init,
	input  wire logic [BSW-1:0]        bs,
	input  wire logic [UCW:0]          steps,
	output logic signed [CW-1:0]       est,
	output logic                       done
);

	localparam int SW   = CW + BSW;
	localparam int DW   = CW + BSW + 1;
	localparam int DENW = BSW + UCW + 1;
	localparam int RMW  = DENW + 1;
	localparam int CNTW = $clog2(DW + 1);

	logic signed [SW-1:0]  sum_q;
	logic signed [CW-1:0]  est_q;
	logic                  neg_q;
	logic [DENW-1:0]       den_q;
	logic [DW-1:0]         quo_q;
	logic [RMW-1:0]        rem_q;
	logic [CNTW-1:0]       cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic signed [DW-1:0]  prod;
	logic signed [DW-1:0]  num;
	logic [DW-1:0]         mag;
	logic [RMW-1:0]        shl;
	logic [RMW-1:0]        trial;
	logic                  ge;
	logic [DW-1:0]         quo_nx;
	logic signed [DW-1:0]  step;
	logic signed [DW-1:0]  est_nx;
	logic signed [SW-1:0]  sum_base;

	assign prod     = $signed({1'b0, bs}) * est_q;
	assign num      = prod - DW'(sum_q);
	assign mag      = num[DW-1] ? DW'(-num) : DW'(num);
	assign shl      = {rem_q[RMW-2:0], quo_q[DW-1]};
	assign trial    = shl - RMW'(den_q);
	assign ge       = shl >= RMW'(den_q);
	assign quo_nx   = {quo_q[DW-2:0], ge};
	assign step     = neg_q ? -$signed(quo_nx) : $signed(quo_nx);
	assign est_nx   = DW'(est_q) - step;
	assign sum_base = ctl.restart ? '0 : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q  <= '0;
			sum_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.acc) begin
				sum_q <= sum_base + SW'(sample);
				if (ctl.restart) begin
					est_q <= init;
				end
			end
			if (ctl.prep) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					est_q  <= est_nx[CW-1:0];
					sum_q  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.prep) begin
			neg_q <= num[DW-1];
			den_q <= bs * steps;
			quo_q <= mag;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= ge ? trial : shl;
		end
	end

	assign est  = est_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== sv/mme_dist.sv =====
// ----------------------------------------------------------------------------
// mme_dist: merge stage
// Squared distance of both lanes' estimates to the target, then a
// bit-serial integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_dist #(
	parameter int CW = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [CW-1:0] est_x,
	input  wire logic signed [CW-1:0] est_y,
	input  wire logic signed [CW-1:0] tgt_x,
	input  wire logic signed [CW-1:0] tgt_y,
	output logic [CW:0]               dist_err,
	output logic                      done
);

	localparam int SQW  = 2 * CW + 4;
	localparam int RW   = CW + 2;
	localparam int CNTW = $clog2(RW + 1);

	logic signed [CW:0]    dx_s1, dy_s1;
	logic [2*CW+1:0]       sqx_s2, sqy_s2;
	logic [SQW-1:0]        n_q;
	logic [RW:0]           rem_q;
	logic [RW-1:0]         root_q;
	logic [2:0]            vld_q;
	logic                  busy_q;
	logic                  done_q;
	logic [CNTW-1:0]       cnt_q;

	logic [RW+2:0]         r2;
	logic [RW+2:0]         trial;
	logic                  ge;

	assign r2    = {rem_q, n_q[SQW-1:SQW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			vld_q  <= {vld_q[1:0], start};
			done_q <= 1'b0;
			if (vld_q[2]) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= (CW+1)'(est_x) - (CW+1)'(tgt_x);
		dy_s1  <= (CW+1)'(est_y) - (CW+1)'(tgt_y);
		sqx_s2 <= (2*CW+2)'(dx_s1 * dx_s1);
		sqy_s2 <= (2*CW+2)'(dy_s1 * dy_s1);
		if (vld_q[2]) begin
			n_q    <= SQW'(sqx_s2) + SQW'(sqy_s2);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[SQW-3:0], 2'b00};
			rem_q  <= ge ? (RW+1)'(r2 - trial) : (RW+1)'(r2);
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign dist_err = root_q[CW:0];
	assign done     = done_q;

endmodule

`default_nettype wire

// ===== sv/minibatch_mean_estimator.sv =====
// ----------------------------------------------------------------------------
// minibatch_mean_estimator: batched 2-D mean estimation
// Samples are summed per batch; on a full batch the estimate steps toward
// the batch mean by 1/(k+1) and its distance to the target is reported.
//
//   channel   dir   handshake               payload
//   s_*       in    s_tvalid/s_tready       tdata {sample_y, sample_x}, tuser start_run
//   m_*       out   m_tvalid/m_tready       tdata {distance_error, estimate_y, estimate_x}
//   cfg_*     in    cfg_valid/cfg_ready     cfg_index, cfg_data
//
// After an item that does not close a batch the input stays ready.
// An item that closes a batch holds the input off while the update runs:
// one prep state, the lane divider, forming and squaring the differences,
// the square root, and the load into the output register.
// Result waits in an output register; input is refused meanwhile only while
// the update runs or a previous result still blocks the output register.
// Reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module minibatch_mean_estimator import mme_pkg::*; #(
	parameter int MAX_BATCH   = 256,
	parameter int COORD_WIDTH = 24,
	localparam int CW    = COORD_WIDTH,
	localparam int IN_W  = ((2 * CW + 7) / 8) * 8,
	localparam int OUT_W = ((3 * CW + 1 + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,   // sample_x, sample_y
	input  wire logic             s_tuser,   // start_run
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // estimate_x, estimate_y, distance_error
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [IDXW-1:0]  cfg_index,
	input  wire logic [CW-1:0]    cfg_data
);

	localparam int CLAMP = (MAX_BATCH < 511) ? MAX_BATCH : 511;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PREP = 5'b00010,
		S_DIV  = 5'b00100,
		S_DIST = 5'b01000,
		S_HOLD = 5'b10000
	} state_t;

	state_t               state_q;
	logic [BSW-1:0]       bs_cfg_q;
	logic signed [CW-1:0] init_x_q, init_y_q, tgt_x_q, tgt_y_q;
	logic [BSW-1:0]       fill_q;
	logic [UCW-1:0]       upd_q;
	logic                 out_vld_q;
	logic [OUT_W-1:0]     out_dat_q;

	logic [BSW-1:0]       bs;
	logic [BSW-1:0]       fill_nx;
	logic                 acc;
	logic                 out_free;
	logic                 load;
	lane_ctl_t            ctl;
	logic signed [CW-1:0] est_x, est_y;
	logic                 done_x, done_y;
	logic [CW:0]          dist_err;
	logic                 dist_done;

	always_comb begin
		if (bs_cfg_q == '0) begin
			bs = BSW'(1);
		end else if (bs_cfg_q > BSW'(CLAMP)) begin
			bs = BSW'(CLAMP);
		end else begin
			bs = bs_cfg_q;
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign acc       = s_tvalid && s_tready;
	assign fill_nx   = (s_tuser ? '0 : fill_q) + 1'b1;
	assign out_free  = !out_vld_q || m_tready;
	assign ctl       = '{acc: acc, restart: s_tuser, prep: (state_q == S_PREP)};
	assign load      = out_free &&
		(((state_q == S_DIST) && dist_done) || (state_q == S_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_cfg_q <= BSW'(1);
			init_x_q <= '0;
			init_y_q <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BATCH_SIZE: bs_cfg_q <= cfg_data[BSW-1:0];
				REG_INITIAL_X:  init_x_q <= cfg_data;
				REG_INITIAL_Y:  init_y_q <= cfg_data;
				REG_TARGET_X:   tgt_x_q  <= cfg_data;
				REG_TARGET_Y:   tgt_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			upd_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (s_tuser) begin
							upd_q <= '0;
						end
						if (fill_nx >= bs) begin
							fill_q  <= '0;
							state_q <= S_PREP;
						end else begin
							fill_q <= fill_nx;
						end
					end
				end
				S_PREP: state_q <= S_DIV;
				S_DIV: begin
					if (done_x) begin
						if (upd_q != '1) begin
							upd_q <= upd_q + 1'b1;
						end
						state_q <= S_DIST;
					end
				end
				S_DIST: begin
					if (dist_done) begin
						state_q <= load ? S_IDLE : S_HOLD;
					end
				end
				S_HOLD: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_dat_q <= OUT_W'({dist_err, est_y, est_x});
		end
	end

	mme_lane #(.CW(CW)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.sample(s_tdata[CW-1:0]), .init(init_x_q), .bs(bs),
		.steps({1'b0, upd_q} + 1'b1), .est(est_x), .done(done_x)
	);

	mme_lane #(.CW(CW)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.sample(s_tdata[2*CW-1:CW]), .init(init_y_q), .bs(bs),
		.steps({1'b0, upd_q} + 1'b1), .est(est_y), .done(done_y)
	);

	mme_dist #(.CW(CW)) u_dist (
		.clk(clk), .arst_n(arst_n), .start((state_q == S_DIV) && done_x && done_y),
		.est_x(est_x), .est_y(est_y), .tgt_x(tgt_x_q), .tgt_y(tgt_y_q),
		.dist_err(dist_err), .done(dist_done)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_dat_q;

endmodule

`default_nettype wire

// ===== sv/mme_check.sv =====
// ----------------------------------------------------------------------------
// mme_check: port-level checks
// Output hold under stall and result timing against input acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_check #(
	parameter int OUT_W = 80
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed under stall");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result right after input item");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result loaded while input open");

endmodule

bind minibatch_mean_estimator mme_check #(.OUT_W(OUT_W)) u_mme_check (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: minibatch_mean_estimator regression
// Streams 2-D samples through the block across several register settings,
// predicts each batch update and distance in a local model, and checks every
// result item in order against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import mme_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 24;
	localparam int UPD_SAT = (1 << 24) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [47:0] s_tdata = '0;   // sample_x, sample_y
	logic s_tuser = 1'b0;        // start_run
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;        // estimate_x, estimate_y, distance_error
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDXW-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;

	minibatch_mean_estimator uut (.*);

	always #10 clk = ~clk;

	typedef struct packed {
		logic [24:0] dist_err;
		logic [23:0] ey;
		logic [23:0] ex;
	} est_t;

	est_t est_q[$];
	int errors = 0;
	bit idle_en = 1'b1;
	bit hold_out = 1'b0;
	int stall_n = 0;

	// local copy of the estimator state
	logic [8:0] bs_r = 9'd1;
	logic signed [23:0] ix_r = 0, iy_r = 0, tx_r = 0, ty_r = 0;
	longint est_x, est_y, sum_x, sum_y;
	int fill, upd;

	function automatic longint isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint step_toward(longint e, longint s, longint b, longint k);
		return e - (b * e - s) / (b * k);
	endfunction

	task automatic restart_est();
		est_x = ix_r;
		est_y = iy_r;
		sum_x = 0;
		sum_y = 0;
		fill = 0;
		upd = 0;
	endtask

	task automatic predict_batch(logic signed [23:0] sx, logic signed [23:0] sy, bit st);
		longint b, dx, dy;
		est_t r;
		b = (bs_r == 0) ? 1 : (bs_r > 256 ? 256 : bs_r);
		if (st) restart_est();
		sum_x += sx;
		sum_y += sy;
		fill++;
		if (fill < b) return;
		est_x = step_toward(est_x, sum_x, b, upd + 1);
		est_y = step_toward(est_y, sum_y, b, upd + 1);
		sum_x = 0;
		sum_y = 0;
		fill = 0;
		if (upd < UPD_SAT) upd++;
		dx = est_x - tx_r;
		dy = est_y - ty_r;
		r.ex = est_x[23:0];
		r.ey = est_y[23:0];
		r.dist_err = 25'(isqrt(dx * dx + dy * dy));
		est_q = {est_q, r};
	endtask

	task automatic idle_gap();
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// s_tvalid stays up after the handshake; an idle gap or a drain drops it
	task automatic send_sample(logic [23:0] sx, logic [23:0] sy, bit st);
		idle_gap();
		s_tvalid <= 1'b1;
		s_tdata <= {sy, sx};
		s_tuser <= st;
		do @(posedge clk); while (!s_tready);
		predict_batch(sx, sy, st);
	endtask

	task automatic write_reg(logic [IDXW-1:0] idx, logic [CW-1:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (last) cfg_valid <= 1'b0;
		case (idx)
			REG_BATCH_SIZE: bs_r = val[8:0];
			REG_INITIAL_X:  ix_r = val;
			REG_INITIAL_Y:  iy_r = val;
			REG_TARGET_X:   tx_r = val;
			REG_TARGET_Y:   ty_r = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (est_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic configure(logic [8:0] b, logic [23:0] ix, logic [23:0] iy,
			logic [23:0] tx, logic [23:0] ty);
		drain();
		write_reg(REG_BATCH_SIZE, 24'(b), 1'b0);
		write_reg(REG_INITIAL_X, ix, 1'b0);
		write_reg(REG_INITIAL_Y, iy, 1'b0);
		write_reg(REG_TARGET_X, tx, 1'b0);
		write_reg(REG_TARGET_Y, ty, 1'b1);
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7fffff;
			2: return 24'($urandom_range(0, 8191) - 4096);
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		configure(9'd1, 24'h0, 24'h0, 24'h0, 24'h0);
		send_sample(24'h7fffff, 24'h7fffff, 1'b1);
		send_sample(24'h800000, 24'h800000, 1'b0);
		send_sample(24'h800000, 24'h7fffff, 1'b0);
		send_sample(24'h0, 24'h0, 1'b0);
		configure(9'd0, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
		send_sample(24'h800000, 24'h7fffff, 1'b1);
		send_sample(24'h7fffff, 24'h800000, 1'b0);
		configure(9'd511, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
		for (int i = 0; i < 3; i++) send_sample(24'h123456, 24'hfedcba, i == 0);
		configure(9'd4, 24'h001000, 24'hfff000, 24'h0, 24'h0);
		send_sample(24'h1000, 24'h2000, 1'b1);
		send_sample(24'h3000, 24'h4000, 1'b0);
		send_sample(24'h5000, 24'h6000, 1'b1);
		for (int i = 0; i < 3; i++) send_sample(24'h7fffff, 24'h800000, 1'b0);
		// lower batch size in mid batch: completes on next sample
		send_sample(24'h1, 24'h2, 1'b0);
		send_sample(24'h3, 24'h4, 1'b0);
		drain();
		write_reg(REG_BATCH_SIZE, 24'd2, 1'b1);
		send_sample(24'h5, 24'h6, 1'b0);
		configure(9'd256, 24'h0, 24'h0, 24'h0, 24'h0);
		for (int i = 0; i < 256; i++) send_sample(rand_coord(), rand_coord(), 1'b0);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_sample(rand_coord(), rand_coord(), $urandom_range(0, 40) == 0);
	endtask

	task automatic test_backpressure();
		configure(9'd1, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		hold_out = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_out = 1'b0;
			end
			begin
				for (int i = 0; i < 10; i++) send_sample(rand_coord(), rand_coord(), 1'b0);
				s_tvalid <= 1'b0;
			end
		join
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		restart_est();
		@(posedge clk);
		test_directed();
		test_backpressure();
		configure(9'd1, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		test_random(600);
		configure(9'd3, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		test_random(400);
		configure(9'($urandom_range(5, 16)), rand_coord(), rand_coord(), rand_coord(),
			rand_coord());
		test_random(300);
		drain();
		idle_en = 1'b0;
		configure(9'd2, rand_coord(), rand_coord(), rand_coord(), rand_coord());
		test_random(300);
		drain();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (hold_out) begin
			m_tready <= 1'b0;
		end else if (stall_n > 0) begin
			stall_n--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 15) == 0) begin
			stall_n = $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		est_t e, a;
		if (arst_n && m_tvalid && m_tready) begin
			a = m_tdata[72:0];
			if (est_q.size() == 0) begin
				$display("%0t unexpected result item %h", $time, a);
				errors++;
			end else begin
				e = est_q.pop_front();
				if (a.ex !== e.ex) begin
					$display("%0t estimate_x exp %h got %h", $time, e.ex, a.ex);
					errors++;
				end
				if (a.ey !== e.ey) begin
					$display("%0t estimate_y exp %h got %h", $time, e.ey, a.ey);
					errors++;
				end
				if (a.dist_err !== e.dist_err) begin
					$display("%0t distance_error exp %h got %h", $time, e.dist_err,
						a.dist_err);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

`default_nettype wire
